// ===== src/avsfp_pkg.sv =====
// Package with the shared types and constants of the frame pacer.
`default_nettype none
package avsfp_pkg;

    localparam int IN_TIME_W   = 40;
    localparam int PTS_W       = 32;
    localparam int QUEUE_W     = 16;
    localparam int SLEEP_W     = 18;
    localparam int FRAME_W     = 10;
    localparam int SPEED_W     = 10;
    localparam int OFFSET_W    = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_TIME = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_AV_OFFSET  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIVE_MODE  = 2'd3;

    localparam logic [FRAME_W-1:0] FRAME_TIME_RESET = 10'd40;
    localparam logic [SPEED_W-1:0] SPEED_RESET      = 10'd100;

    localparam int PERCENT      = 100;
    localparam int INTERVAL_TOL = 5;
    localparam int DRIFT_LARGE  = 500;
    localparam int DRIFT_MID    = 50;
    localparam int DRIFT_SMALL  = 30;

    localparam int PERIOD_W      = 17;
    localparam int DIV_W         = 50;
    localparam int DIVISOR_W     = 10;
    localparam int DIV_STEP_W    = 5;
    localparam int SYS_QUOT_W    = 44;
    localparam logic [DIV_STEP_W-1:0] DIV_STEPS_SYS    = DIV_STEP_W'(DIV_W / 2);
    localparam logic [DIV_STEP_W-1:0] DIV_STEPS_PERIOD = 5'd9;

    typedef struct packed {
        logic        [IN_TIME_W-1:0] now_ms;
        logic signed [PTS_W-1:0]     audio_pts;
        logic signed [PTS_W-1:0]     video_pts;
        logic        [QUEUE_W-1:0]   audio_packets_queued;
        logic        [QUEUE_W-1:0]   video_packets_queued;
        logic signed [PTS_W-1:0]     start_pts;
        logic        [IN_TIME_W-1:0] start_tick;
    } t_in_item;

    typedef struct packed {
        logic        [SLEEP_W-1:0] sleep_ms;
        logic signed [PTS_W-1:0]   sync_diff;
        logic                      play_completed;
        logic                      completed_event;
    } t_out_item;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  value;
    } t_cfg_item;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_sys;
        logic cap_period;
        logic calc_drift;
        logic adjust;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_status;

endpackage
`default_nettype wire

// ===== src/avsfp_if.sv =====
// Valid/ready channel interfaces for the input, result and configuration transfers.
`default_nettype none
interface avsfp_in_if;
    logic                valid;
    logic                ready;
    avsfp_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface avsfp_out_if;
    logic                 valid;
    logic                 ready;
    avsfp_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface avsfp_cfg_if;
    logic                 valid;
    logic                 ready;
    avsfp_pkg::t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/avsfp_div.sv =====
// Unsigned restoring divider that retires two quotient bits per cycle.
`default_nettype none
module avsfp_div (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic [avsfp_pkg::DIV_W-1:0]           i_dividend,
    input  wire logic [avsfp_pkg::DIVISOR_W-1:0]       i_divisor,
    input  wire logic [avsfp_pkg::DIV_STEP_W-1:0]      i_steps,
    output logic                                       o_busy,
    output logic [avsfp_pkg::DIV_W-1:0]                o_quot
);
    localparam int DW = avsfp_pkg::DIVISOR_W;
    localparam int NW = avsfp_pkg::DIV_W;

    logic [avsfp_pkg::DIV_STEP_W-1:0] r_cnt, n_cnt;
    logic [NW-1:0] r_num, n_num;
    logic [NW-1:0] r_quot, n_quot;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_div;
    logic [DW:0]   trial1, trial2;
    logic [DW-1:0] rem1;
    logic          q1, q2;

    always_comb begin
        trial1 = {r_rem, r_num[NW-1]};
        q1     = trial1 >= {1'b0, r_div};
        rem1   = q1 ? DW'(trial1 - {1'b0, r_div}) : trial1[DW-1:0];
        trial2 = {rem1, r_num[NW-2]};
        q2     = trial2 >= {1'b0, r_div};
        n_rem  = q2 ? DW'(trial2 - {1'b0, r_div}) : trial2[DW-1:0];
        n_num  = {r_num[NW-3:0], 2'b00};
        n_quot = {r_quot[NW-3:0], q1, q2};
        n_cnt  = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_steps;
        end else if (o_busy) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_dividend;
            r_div  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (o_busy) begin
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

// ===== src/avsfp_dp.sv =====
// Datapath of the frame pacer: configuration, pacing state, arithmetic and result register.
`default_nettype none
module avsfp_dp #(
    parameter int IDLE_FRAMES = 10
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire avsfp_pkg::t_cmd                       i_cmd,
    output avsfp_pkg::t_status                         o_status,
    input  wire avsfp_pkg::t_in_item                   i_in_data,
    input  wire logic                                  i_cfg_we,
    input  wire avsfp_pkg::t_cfg_item                  i_cfg_data,
    output avsfp_pkg::t_out_item                       o_out_data
);
    localparam int IDLE_W = $clog2(IDLE_FRAMES + 1);
    localparam int TW     = avsfp_pkg::IN_TIME_W;
    localparam int PW     = avsfp_pkg::PERIOD_W;
    localparam int SW     = avsfp_pkg::SLEEP_W;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] res;
        if (v > 48'sh0000_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -48'sh0000_8000_0000) begin
            res = -32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    logic [avsfp_pkg::FRAME_W-1:0]         r_frame_time;
    logic [avsfp_pkg::SPEED_W-1:0]         r_speed;
    logic signed [avsfp_pkg::OFFSET_W-1:0] r_offset;
    logic                                  r_live;

    logic [31:0]      r_seen_apts, r_seen_vpts;
    logic [IDLE_W-1:0] r_idle, n_idle;
    logic             r_flag, n_flag, n_event, r_event;
    logic [TW-1:0]    r_last_tick;
    logic [SW-1:0]    r_sleep, n_sleep;

    logic signed [31:0] r_apts, r_spts, r_interval, r_drift, n_drift;
    logic signed [32:0] r_vo;
    logic               r_vneg, r_neg;
    logic [TW-1:0]      r_mag, n_mag;
    logic [avsfp_pkg::DIV_W-1:0] r_prod;
    logic [PW-1:0]      r_period;
    avsfp_pkg::t_out_item r_out;

    logic [avsfp_pkg::SPEED_W-1:0]  speed_eff;
    logic [PW-1:0]                  period_num;
    logic signed [TW:0]             delta, ival;
    logic [avsfp_pkg::DIV_W-1:0]    div_dividend;
    logic [avsfp_pkg::DIVISOR_W-1:0] div_divisor;
    logic [avsfp_pkg::DIV_STEP_W-1:0] div_steps;
    logic [avsfp_pkg::DIV_W-1:0]    div_quot;
    logic                           div_busy;
    logic signed [45:0]             sys_q;
    logic signed [47:0]             sys_diff, aud_diff;
    logic signed [33:0]             idiff;
    logic signed [3:0]              adj;
    logic signed [20:0]             s_adj, s_limit;

    assign speed_eff  = (r_speed == '0) ? avsfp_pkg::SPEED_W'(1) : r_speed;
    assign period_num = PW'(r_frame_time) * PW'(avsfp_pkg::PERCENT);

    always_comb begin
        if (i_cmd.div_sys) begin
            div_dividend = r_prod;
            div_divisor  = avsfp_pkg::DIVISOR_W'(avsfp_pkg::PERCENT);
            div_steps    = avsfp_pkg::DIV_STEPS_SYS;
        end else begin
            div_dividend = {1'b0, period_num, {(avsfp_pkg::DIV_W - PW - 1){1'b0}}};
            div_divisor  = speed_eff;
            div_steps    = avsfp_pkg::DIV_STEPS_PERIOD;
        end
    end

    avsfp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    assign o_status.div_busy = div_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_time <= avsfp_pkg::FRAME_TIME_RESET;
            r_speed      <= avsfp_pkg::SPEED_RESET;
            r_offset     <= '0;
            r_live       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_data.index)
                avsfp_pkg::CFG_FRAME_TIME: begin
                    r_frame_time <= i_cfg_data.value[avsfp_pkg::FRAME_W-1:0];
                end
                avsfp_pkg::CFG_SPEED: begin
                    r_speed <= i_cfg_data.value[avsfp_pkg::SPEED_W-1:0];
                end
                avsfp_pkg::CFG_AV_OFFSET: begin
                    r_offset <= $signed(i_cfg_data.value[avsfp_pkg::OFFSET_W-1:0]);
                end
                avsfp_pkg::CFG_LIVE_MODE: begin
                    r_live <= i_cfg_data.value[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_idle  = r_idle;
        n_flag  = r_flag;
        n_event = 1'b0;
        if (r_seen_apts != i_in_data.audio_pts || r_seen_vpts != i_in_data.video_pts) begin
            n_idle = '0;
            n_flag = 1'b0;
        end else if (i_in_data.audio_packets_queued == '0
                     && i_in_data.video_packets_queued == '0
                     && r_idle < IDLE_W'(IDLE_FRAMES)) begin
            n_idle = r_idle + 1'b1;
            if (n_idle == IDLE_W'(IDLE_FRAMES)) begin
                n_flag  = 1'b1;
                n_event = 1'b1;
            end
        end
        delta = $signed({1'b0, i_in_data.now_ms}) - $signed({1'b0, i_in_data.start_tick});
        n_mag = delta[TW] ? TW'(-delta) : delta[TW-1:0];
        ival  = $signed({1'b0, i_in_data.now_ms}) - $signed({1'b0, r_last_tick});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_apts <= '0;
            r_seen_vpts <= '0;
            r_idle      <= '0;
            r_flag      <= 1'b0;
            r_last_tick <= '0;
        end else if (i_cmd.load) begin
            r_seen_apts <= i_in_data.audio_pts;
            r_seen_vpts <= i_in_data.video_pts;
            r_idle      <= n_idle;
            r_flag      <= n_flag;
            r_last_tick <= i_in_data.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= avsfp_pkg::DIV_W'(r_mag * speed_eff);
        if (i_cmd.load) begin
            r_event    <= n_event;
            r_apts     <= i_in_data.audio_pts;
            r_spts     <= i_in_data.start_pts;
            r_vo       <= 33'(i_in_data.video_pts) + 33'(r_offset);
            r_vneg     <= i_in_data.video_pts[31];
            r_neg      <= delta[TW];
            r_mag      <= n_mag;
            r_interval <= sat32(48'(ival));
        end
        if (i_cmd.cap_period) begin
            r_period <= div_quot[PW-1:0];
        end
        if (i_cmd.calc_drift) begin
            r_drift <= n_drift;
        end
        if (i_cmd.out_load) begin
            r_out.sleep_ms        <= r_live ? '0 : r_sleep;
            r_out.sync_diff       <= r_drift;
            r_out.play_completed  <= r_flag;
            r_out.completed_event <= r_event;
        end
    end

    always_comb begin
        sys_q    = r_neg ? -$signed({2'b00, div_quot[avsfp_pkg::SYS_QUOT_W-1:0]})
                         : $signed({2'b00, div_quot[avsfp_pkg::SYS_QUOT_W-1:0]});
        sys_diff = 48'(r_spts) + 48'(sys_q) - 48'(r_vo);
        aud_diff = 48'(r_apts) - 48'(r_vo);
        n_drift  = sat32((r_apts > 32'sd0) ? aud_diff : sys_diff);
    end

    always_comb begin
        idiff = 34'(r_interval) - $signed({17'b0, r_period});
        adj   = '0;
        if (idiff > 34'(avsfp_pkg::INTERVAL_TOL)) begin
            adj = adj - 4'sd1;
        end
        if (idiff < 34'(-avsfp_pkg::INTERVAL_TOL)) begin
            adj = adj + 4'sd1;
        end
        if (!r_vneg) begin
            priority if (r_drift > 32'(avsfp_pkg::DRIFT_LARGE)) begin
                adj = adj - 4'sd3;
            end else if (r_drift > 32'(avsfp_pkg::DRIFT_MID)) begin
                adj = adj - 4'sd2;
            end else if (r_drift > 32'(avsfp_pkg::DRIFT_SMALL)) begin
                adj = adj - 4'sd1;
            end else if (r_drift < 32'(-avsfp_pkg::DRIFT_LARGE)) begin
                adj = adj + 4'sd3;
            end else if (r_drift < 32'(-avsfp_pkg::DRIFT_MID)) begin
                adj = adj + 4'sd2;
            end else if (r_drift < 32'(-avsfp_pkg::DRIFT_SMALL)) begin
                adj = adj + 4'sd1;
            end else begin
            end
        end
        s_adj   = $signed({3'b000, r_sleep}) + 21'(adj);
        s_limit = $signed({3'b000, r_period, 1'b0});
        if (s_adj > s_limit) begin
            s_adj = s_limit;
        end
        if (s_adj < 21'sd0) begin
            s_adj = '0;
        end
        n_sleep = s_adj[SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sleep <= SW'(avsfp_pkg::FRAME_TIME_RESET);
        end else if (i_cmd.adjust) begin
            r_sleep <= n_sleep;
        end
    end

    assign o_out_data = r_out;
endmodule
`default_nettype wire

// ===== src/avsfp_ctrl.sv =====
// Controller state machine that sequences one frame through the datapath.
`default_nettype none
module avsfp_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    input  wire avsfp_pkg::t_status i_status,
    output avsfp_pkg::t_cmd         o_cmd
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIVP = 6'b000010,
        S_DIVS = 6'b000100,
        S_SYNC = 6'b001000,
        S_ADJ  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVP;
                end
            end
            S_DIVP: begin
                if (!i_status.div_busy) begin
                    o_cmd.cap_period = 1'b1;
                    o_cmd.div_start  = 1'b1;
                    o_cmd.div_sys    = 1'b1;
                    n_state          = S_DIVS;
                end
            end
            S_DIVS: begin
                if (!i_status.div_busy) begin
                    n_state = S_SYNC;
                end
            end
            S_SYNC: begin
                o_cmd.calc_drift = 1'b1;
                n_state          = S_ADJ;
            end
            S_ADJ: begin
                o_cmd.adjust = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

// ===== src/av_sync_frame_pacer.sv =====
// Top level of the audio-video frame pacer.
//
// Each input transfer describes one rendered frame; the block returns one result
// transfer with the sleep time, the measured drift and the end-of-playback flags.
// A frame occupies the block until its result is loaded into the output register, plus
// any wait for that register. Its sequence uses one shared divider retiring two quotient
// bits per cycle, which runs 9 steps for the speed-scaled frame period and 25 steps for the system clock.
// A finished result waits in the output register while the next frame is accepted.
// Configuration writes are always accepted and should be issued while no frame is
// in flight.
`default_nettype none
module av_sync_frame_pacer #(
    parameter int IDLE_FRAMES = 10
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    avsfp_in_if.sink    i_in,
    avsfp_out_if.source o_out,
    avsfp_cfg_if.sink   i_cfg
);
    avsfp_pkg::t_cmd    cmd;
    avsfp_pkg::t_status status;

    assign i_cfg.ready = 1'b1;

    avsfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    avsfp_dp #(
        .IDLE_FRAMES (IDLE_FRAMES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_in_data  (i_in.data),
        .i_cfg_we   (i_cfg.valid && i_cfg.ready),
        .i_cfg_data (i_cfg.data),
        .o_out_data (o_out.data)
    );

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider restarted while busy");

    a_load_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> status.div_busy)
        else $error("divider not running after frame load");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out.valid || o_out.ready))
        else $error("result register overwritten before transfer");

    a_event_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.completed_event) |-> o_out.data.play_completed)
        else $error("completion event without completion flag");
endmodule
`default_nettype wire
